[src/bspt_pkg.sv]
// Shared types, constants and helpers for the barometer poll and temperature
// compensation block. Used by every module under src; depends on nothing.
`default_nettype none

package bspt_pkg;

    localparam int CAL_W          = 16;
    localparam int TICK_W         = 17;
    localparam int TEMP_WAIT_DEF  = 5;
    localparam int PRESS_WAIT_DEF = 15;
    localparam logic [CAL_W-1:0] SLEEP_RESET = 16'd100;

    // Quotient width of the correction divide: |cal_mc| * 2^11 needs 27 bits.
    localparam int DIV_BITS = 27;
    // The step counter runs from 0 up to DIV_BITS.
    localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

    typedef enum logic [2:0] {
        REG_AC5   = 3'd0,
        REG_AC6   = 3'd1,
        REG_MC    = 3'd2,
        REG_MD    = 3'd3,
        REG_SLEEP = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        ACT_NONE       = 3'd0,
        ACT_START_TEMP = 3'd1,
        ACT_READ_TEMP  = 3'd2,
        ACT_START_PRES = 3'd3,
        ACT_READ_PRES  = 3'd4
    } t_bus_action;

    typedef enum logic [7:0] {
        PH_START  = 8'b0000_0001,
        PH_REQ_T  = 8'b0000_0010,
        PH_WAIT_T = 8'b0000_0100,
        PH_READ_T = 8'b0000_1000,
        PH_REQ_P  = 8'b0001_0000,
        PH_WAIT_P = 8'b0010_0000,
        PH_READ_P = 8'b0100_0000,
        PH_SLEEP  = 8'b1000_0000
    } t_phase;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b00_0001,
        S_MUL   = 6'b00_0010,
        S_X1    = 6'b00_0100,
        S_SETUP = 6'b00_1000,
        S_DIV   = 6'b01_0000,
        S_OUT   = 6'b10_0000
    } t_ctrl_state;

    typedef struct packed {
        logic diff_load;
        logic mul_load;
        logic x1_load;
        logic div_start;
        logic div_step;
        logic fin_load;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_sts;

    // Binary phase number as seen on the result channel.
    function automatic logic [2:0] phase_code(input t_phase p);
        logic [2:0] code;
        unique case (p)
            PH_START:  code = 3'd0;
            PH_REQ_T:  code = 3'd1;
            PH_WAIT_T: code = 3'd2;
            PH_READ_T: code = 3'd3;
            PH_REQ_P:  code = 3'd4;
            PH_WAIT_P: code = 3'd5;
            PH_READ_P: code = 3'd6;
            PH_SLEEP:  code = 3'd7;
            default:   code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[src/bspt_seq.sv]
// Eight-phase bus sequencer: advances once per accepted tick and holds the
// pending bus action, update flag and phase for the result. Uses bspt_pkg.
`default_nettype none

module bspt_seq #(
    parameter int TEMP_WAIT_TICKS  = bspt_pkg::TEMP_WAIT_DEF,
    parameter int PRESS_WAIT_TICKS = bspt_pkg::PRESS_WAIT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_tick,
    input  wire logic [bspt_pkg::CAL_W-1:0] i_sleep_ticks,
    output logic                            o_is_read,
    output logic [2:0]                      o_bus_action,
    output logic                            o_temp_updated,
    output logic [2:0]                      o_phase_now
);

    localparam logic [bspt_pkg::TICK_W-1:0] TEMP_LIM  =
        TEMP_WAIT_TICKS[bspt_pkg::TICK_W-1:0];
    localparam logic [bspt_pkg::TICK_W-1:0] PRESS_LIM =
        PRESS_WAIT_TICKS[bspt_pkg::TICK_W-1:0];

    bspt_pkg::t_phase            r_phase, n_phase;
    logic [bspt_pkg::TICK_W-1:0] r_tick, n_tick, c_tick_inc;
    bspt_pkg::t_bus_action       r_act, n_act;
    logic                        r_upd, n_upd;

    assign c_tick_inc = r_tick + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_tick  = '0;
        n_act   = bspt_pkg::ACT_NONE;
        n_upd   = 1'b0;
        unique case (r_phase)
            bspt_pkg::PH_START: begin
                n_phase = bspt_pkg::PH_REQ_T;
            end
            bspt_pkg::PH_REQ_T: begin
                n_act   = bspt_pkg::ACT_START_TEMP;
                n_phase = bspt_pkg::PH_WAIT_T;
            end
            bspt_pkg::PH_WAIT_T: begin
                if (c_tick_inc >= TEMP_LIM) begin
                    n_phase = bspt_pkg::PH_READ_T;
                end else begin
                    n_tick = c_tick_inc;
                end
            end
            bspt_pkg::PH_READ_T: begin
                n_act   = bspt_pkg::ACT_READ_TEMP;
                n_upd   = 1'b1;
                n_phase = bspt_pkg::PH_REQ_P;
            end
            bspt_pkg::PH_REQ_P: begin
                n_act   = bspt_pkg::ACT_START_PRES;
                n_phase = bspt_pkg::PH_WAIT_P;
            end
            bspt_pkg::PH_WAIT_P: begin
                if (c_tick_inc >= PRESS_LIM) begin
                    n_phase = bspt_pkg::PH_READ_P;
                end else begin
                    n_tick = c_tick_inc;
                end
            end
            bspt_pkg::PH_READ_P: begin
                n_act   = bspt_pkg::ACT_READ_PRES;
                n_phase = bspt_pkg::PH_SLEEP;
            end
            bspt_pkg::PH_SLEEP: begin
                // Sleep lasts sleep_ticks + 1 ticks.
                if (c_tick_inc > {1'b0, i_sleep_ticks}) begin
                    n_phase = bspt_pkg::PH_START;
                end else begin
                    n_tick = c_tick_inc;
                end
            end
            default: begin
                n_phase = bspt_pkg::PH_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= bspt_pkg::PH_START;
            r_tick  <= '0;
            r_act   <= bspt_pkg::ACT_NONE;
            r_upd   <= 1'b0;
        end else if (i_tick) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_act   <= n_act;
            r_upd   <= n_upd;
        end
    end

    assign o_is_read      = (r_phase == bspt_pkg::PH_READ_T);
    assign o_bus_action   = r_act;
    assign o_temp_updated = r_upd;
    assign o_phase_now    = bspt_pkg::phase_code(r_phase);

endmodule

`default_nettype wire

[src/bspt_dp.sv]
// Compensation datapath: offset and gain multiply, serial restoring divider
// for the correction term, final rounding and saturation. Uses bspt_pkg.
`default_nettype none

module bspt_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire bspt_pkg::t_dp_cmd                 i_cmd,
    output bspt_pkg::t_dp_sts                      o_sts,
    input  wire logic        [bspt_pkg::CAL_W-1:0] i_raw_temp,
    input  wire logic        [bspt_pkg::CAL_W-1:0] i_ac5,
    input  wire logic        [bspt_pkg::CAL_W-1:0] i_ac6,
    input  wire logic signed [bspt_pkg::CAL_W-1:0] i_mc,
    input  wire logic signed [bspt_pkg::CAL_W-1:0] i_md,
    output logic signed      [bspt_pkg::CAL_W-1:0] o_temperature
);

    localparam int QB = bspt_pkg::DIV_BITS;

    logic signed [16:0] r_diff, c_diff;
    logic signed [33:0] r_prod;
    logic signed [17:0] r_x1, c_x1;
    logic signed [18:0] c_den;
    logic [17:0]        c_den_mag;
    logic [15:0]        c_mc_mag;

    logic [17:0]        r_rem, r_dvs;
    logic [QB-1:0]      r_quo;
    logic               r_neg, r_dzero;
    logic [bspt_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [18:0]        c_shift, c_sub;
    logic               c_ge;

    logic signed [QB:0]   c_x2;
    logic signed [QB+1:0] c_sum;
    logic signed [QB-3:0] c_t;
    logic signed [15:0]   c_sat, r_last_temp;

    assign c_diff = $signed({1'b0, i_raw_temp}) - $signed({1'b0, i_ac6});

    // The product stays below 2^32 in magnitude, so x1 fits 18 signed bits.
    assign c_x1  = r_prod[32:15];
    assign c_den = {c_x1[17], c_x1} + {{3{i_md[15]}}, i_md};

    logic [18:0] c_den_abs;
    assign c_den_abs = c_den[18] ? (~c_den + 19'd1) : c_den;
    assign c_den_mag = c_den_abs[17:0];
    assign c_mc_mag  = i_mc[15] ? (~i_mc + 16'd1) : i_mc;

    assign c_shift = {r_rem, r_quo[QB-1]};
    assign c_ge    = (c_shift >= {1'b0, r_dvs});
    assign c_sub   = c_shift - {1'b0, r_dvs};

    // x2 truncates toward zero: the magnitude quotient takes the sign back.
    always_comb begin
        if (r_dzero) begin
            c_x2 = '0;
        end else if (r_neg) begin
            c_x2 = -$signed({1'b0, r_quo});
        end else begin
            c_x2 = $signed({1'b0, r_quo});
        end
    end

    assign c_sum = {{(QB-16){r_x1[17]}}, r_x1} + {c_x2[QB], c_x2}
                   + (QB+2)'(8);
    assign c_t   = c_sum[QB+1:4];

    always_comb begin
        if (c_t[QB-3:15] == '0 || c_t[QB-3:15] == '1) begin
            c_sat = c_t[15:0];
        end else if (c_t[QB-3]) begin
            c_sat = 16'sh8000;
        end else begin
            c_sat = 16'sh7fff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.diff_load) begin
            r_diff <= c_diff;
        end
        if (i_cmd.mul_load) begin
            r_prod <= r_diff * $signed({1'b0, i_ac5});
        end
        if (i_cmd.x1_load) begin
            r_x1    <= c_x1;
            r_dvs   <= c_den_mag;
            r_neg   <= i_mc[15] ^ c_den[18];
            r_dzero <= (c_den == '0);
        end
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= {c_mc_mag, 11'b0};
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= c_ge ? c_sub[17:0] : c_shift[17:0];
            r_quo <= {r_quo[QB-2:0], c_ge};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_temp <= '0;
        end else if (i_cmd.fin_load) begin
            r_last_temp <= c_sat;
        end
    end

    // All QB quotient bits are in once the counter has reached QB.
    assign o_sts.div_last = (r_cnt == bspt_pkg::DIV_CNT_W'(QB));
    assign o_temperature  = r_last_temp;

endmodule

`default_nettype wire

[src/bspt_ctrl.sv]
// Controller state machine that accepts ticks and steps the compensation
// datapath through multiply, divide and result load. Uses bspt_pkg.
`default_nettype none

module bspt_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_is_read,
    input  wire logic              i_out_free,
    input  wire bspt_pkg::t_dp_sts i_sts,
    output logic                   o_in_ready,
    output logic                   o_tick,
    output logic                   o_out_load,
    output bspt_pkg::t_dp_cmd      o_cmd
);

    bspt_pkg::t_ctrl_state r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_tick     = 1'b0;
        o_out_load = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            bspt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_tick = 1'b1;
                    if (i_is_read) begin
                        o_cmd.diff_load = 1'b1;
                        n_state = bspt_pkg::S_MUL;
                    end else begin
                        n_state = bspt_pkg::S_OUT;
                    end
                end
            end
            bspt_pkg::S_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state = bspt_pkg::S_X1;
            end
            bspt_pkg::S_X1: begin
                o_cmd.x1_load = 1'b1;
                n_state = bspt_pkg::S_SETUP;
            end
            bspt_pkg::S_SETUP: begin
                o_cmd.div_start = 1'b1;
                n_state = bspt_pkg::S_DIV;
            end
            bspt_pkg::S_DIV: begin
                if (i_sts.div_last) begin
                    o_cmd.fin_load = 1'b1;
                    n_state = bspt_pkg::S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            bspt_pkg::S_OUT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state = bspt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bspt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bspt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[src/baro_sensor_poll_temp_comp_top.sv]
// Top level of the barometer poll sequencer with temperature compensation.
// Holds the calibration registers and result register; uses bspt_pkg,
// bspt_seq, bspt_dp and bspt_ctrl.
`default_nettype none

//  Channel  | Valid        | Ready        | Payload
//  ---------+--------------+--------------+-------------------------------------
//  tick in  | i_valid      | o_ready      | i_raw_temp
//  result   | o_valid      | i_ready      | o_bus_action, o_temperature,
//           |              |              | o_temp_updated, o_phase_now
//  config   | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A tick in any phase other than the temperature read goes from the transfer
// to S_OUT, which loads the result register once it is free and then makes the
// input ready again. A temperature-read tick steps through the offset subtract
// at the transfer, one multiply, x1 and the divisor, divider setup, the
// one-bit-per-cycle restoring divider for all 27 quotient bits, rounding and
// saturation, and the load of the result register. One tick is in flight at a
// time; the next one is taken while the previous result still waits in the
// result register. Reset is synchronous and active low. The config port never
// stalls.

module baro_sensor_poll_temp_comp_top #(
    parameter int TEMP_WAIT_TICKS  = bspt_pkg::TEMP_WAIT_DEF,
    parameter int PRESS_WAIT_TICKS = bspt_pkg::PRESS_WAIT_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // Tick input channel.
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [bspt_pkg::CAL_W-1:0] i_raw_temp,
    // Result channel.
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [2:0]                      o_bus_action,
    output logic signed [bspt_pkg::CAL_W-1:0] o_temperature,
    output logic                            o_temp_updated,
    output logic [2:0]                      o_phase_now,
    // Configuration write channel.
    input  wire logic                       i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire logic [2:0]                 i_cfg_index,
    input  wire logic [bspt_pkg::CAL_W-1:0] i_cfg_data
);

    // Calibration and sleep registers.
    logic [bspt_pkg::CAL_W-1:0]        r_ac5, r_ac6, r_sleep;
    logic signed [bspt_pkg::CAL_W-1:0] r_mc, r_md;

    // Handshake between the controller, sequencer and datapath.
    logic               c_tick, c_is_read, c_out_load, c_out_free;
    bspt_pkg::t_dp_cmd  c_cmd;
    bspt_pkg::t_dp_sts  c_sts;

    logic [2:0]                        c_act, c_phase;
    logic                              c_upd;
    logic signed [bspt_pkg::CAL_W-1:0] c_temp;

    // Result register; it frees up in the same cycle its transfer completes.
    logic                              r_out_valid;
    logic [2:0]                        r_act, r_phase;
    logic                              r_upd;
    logic signed [bspt_pkg::CAL_W-1:0] r_temp;

    assign o_cfg_ready = 1'b1;

    // Writes to indexes past the register list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac5   <= '0;
            r_ac6   <= '0;
            r_mc    <= '0;
            r_md    <= '0;
            r_sleep <= bspt_pkg::SLEEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bspt_pkg::REG_AC5:   r_ac5   <= i_cfg_data;
                bspt_pkg::REG_AC6:   r_ac6   <= i_cfg_data;
                bspt_pkg::REG_MC:    r_mc    <= i_cfg_data;
                bspt_pkg::REG_MD:    r_md    <= i_cfg_data;
                bspt_pkg::REG_SLEEP: r_sleep <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bspt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_is_read  (c_is_read),
        .i_out_free (c_out_free),
        .i_sts      (c_sts),
        .o_in_ready (o_ready),
        .o_tick     (c_tick),
        .o_out_load (c_out_load),
        .o_cmd      (c_cmd)
    );

    bspt_seq #(
        .TEMP_WAIT_TICKS  (TEMP_WAIT_TICKS),
        .PRESS_WAIT_TICKS (PRESS_WAIT_TICKS)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (c_tick),
        .i_sleep_ticks  (r_sleep),
        .o_is_read      (c_is_read),
        .o_bus_action   (c_act),
        .o_temp_updated (c_upd),
        .o_phase_now    (c_phase)
    );

    bspt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (c_cmd),
        .o_sts         (c_sts),
        .i_raw_temp    (i_raw_temp),
        .i_ac5         (r_ac5),
        .i_ac6         (r_ac6),
        .i_mc          (r_mc),
        .i_md          (r_md),
        .o_temperature (c_temp)
    );

    assign c_out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_out_load) begin
            r_act   <= c_act;
            r_temp  <= c_temp;
            r_upd   <= c_upd;
            r_phase <= c_phase;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_bus_action   = r_act;
    assign o_temperature  = r_temp;
    assign o_temp_updated = r_upd;
    assign o_phase_now    = r_phase;

endmodule

`default_nettype wire
